[rtl/cwc2d_pkg.sv]
// Package for the planar contact wrench cone core: shared widths, stage types
// and the square-root and division step functions used by the core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package cwc2d_pkg;

   localparam int FIELD_W        = 32;
   localparam int MU_W           = 20;
   localparam int LEN_W          = 32;
   localparam int ROOT_ITERS     = 32;
   localparam int ROOT_PER_STAGE = 2;
   localparam int ROOT_STAGES    = ROOT_ITERS / ROOT_PER_STAGE;
   localparam int DIV_PER_STAGE  = 2;

   // Partial state of a digit-by-digit square root of a 64-bit value.
   typedef struct packed {
      logic [63:0] v;
      logic [63:0] r;
   } root_type;

   // Partial remainder and the quotient bit of one restoring division step.
   typedef struct packed {
      logic [LEN_W-1:0] rem;
      logic             q;
   } div_type;

   // Contact data that rides along with the normal through the pipeline.
   typedef struct packed {
      logic signed [FIELD_W-1:0] px;
      logic signed [FIELD_W-1:0] py;
      logic                      sx;
      logic                      sy;
      logic                      zr;
   } side_type;

   // One root iteration; iteration k tests the bit of weight 4^(31-k).
   function automatic root_type root_step(input root_type a, input logic [4:0] k);
      root_type    res;
      logic [63:0] bt;
      logic [63:0] trial;
      bt    = 64'd1 << (6'd62 - {k, 1'b0});
      trial = a.r + bt;
      if (a.v >= trial) begin
         res.v = a.v - trial;
         res.r = (a.r >> 1) + bt;
      end else begin
         res.v = a.v;
         res.r = a.r >> 1;
      end
      return res;
   endfunction

   // One restoring division step; the remainder stays below the divisor.
   function automatic div_type div_step(input logic [LEN_W-1:0] rem, input logic nb,
                                        input logic [LEN_W-1:0] len);
      div_type      res;
      logic [LEN_W:0] t;
      logic [LEN_W:0] d;
      t = {rem, nb};
      d = t - {1'b0, len};
      if (t >= {1'b0, len}) begin
         res.rem = d[LEN_W-1:0];
         res.q   = 1'b1;
      end else begin
         res.rem = t[LEN_W-1:0];
         res.q   = 1'b0;
      end
      return res;
   endfunction

endpackage

`default_nettype wire

[rtl/contact_wrench_cone_2d_core.sv]
// Planar contact wrench cone core: one request per cycle unless the output stalls or
// the cone scales are updating; the 16-stage square-root pipeline and the
// two-bits-per-stage divider normalize the normal.
// A write to csr_wr_data recomputes the cone scales serially; req_tready is low
// throughout (scale loop, 32 root steps, one setup state, FRAC_BITS+1 divide steps).
// A write during an update restarts it.
// Synchronous reset clears all valid bits, sets mu to zero, ca to 1.0 and cb to zero.
`timescale 1ns / 1ps
`default_nettype none

module contact_wrench_cone_2d_core
   import cwc2d_pkg::*;
#(
   parameter int DATA_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // pos_x, pos_y, normal_x, normal_y
   input  wire logic [4*FIELD_W-1:0]     req_tdata,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   // normal_fx, normal_fy, normal_torque, tangent_fx, tangent_fy, tangent_torque,
   // left_edge_fx, left_edge_fy, left_edge_torque,
   // right_edge_fx, right_edge_fy, right_edge_torque
   output logic [12*FIELD_W-1:0]         rsp_tdata,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   input  wire logic                     csr_wr_en,
   input  wire logic [MU_W-1:0]          csr_wr_data
);

   localparam int QW         = FRAC_BITS + 1;
   localparam int NW         = FRAC_BITS + 33;
   localparam int DIRW       = FRAC_BITS + 3;
   localparam int CW         = FRAC_BITS + 1;
   localparam int PRW        = CW + 1 + DIRW;
   localparam int TPW        = FIELD_W + DIRW;
   localparam int TRW        = FIELD_W + DIRW + 1;
   localparam int SAT_W      = (DATA_WIDTH < 32) ? DATA_WIDTH : 32;
   localparam int DIV_STAGES = (QW + DIV_PER_STAGE - 1) / DIV_PER_STAGE;
   localparam logic [63:0] D_ONE   = 64'd1 << (2 * FRAC_BITS);
   localparam logic [63:0] D_LIMIT = 64'd1 << 60;

   typedef enum logic [2:0] {
      CFG_IDLE,
      CFG_SCALE,
      CFG_ROOT,
      CFG_PREP,
      CFG_DIV
   } cfg_state_type;

   function automatic logic signed [TRW-1:0] rnd_frac(input logic signed [TRW-1:0] s);
      logic [TRW-1:0] m;
      logic [TRW-1:0] q;
      m = s[TRW-1] ? TRW'(-s) : TRW'(s);
      q = (m + (TRW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      return s[TRW-1] ? -$signed(q) : $signed(q);
   endfunction

   function automatic logic [FIELD_W-1:0] sat_out(input logic signed [TRW-1:0] s);
      logic signed [TRW-1:0] hi;
      logic signed [TRW-1:0] lo;
      hi = $signed((TRW'(1) << (SAT_W - 1)) - TRW'(1));
      lo = ~hi;
      if (s > hi) begin
         return FIELD_W'(hi);
      end else if (s < lo) begin
         return FIELD_W'(lo);
      end
      return FIELD_W'(s);
   endfunction

   // ---------------------------------------------------------------- cone scales
   cfg_state_type   cfg_state_ff, cfg_state_in;
   logic [MU_W-1:0] mu_ff, mu_in;
   logic [63:0]     cd_ff, cd_in;
   logic [4:0]      ch_ff, ch_in;
   root_type        croot_ff, croot_in;
   logic [4:0]      ck_ff, ck_in;
   logic [63:0]     cna_ff, cna_in, cnb_ff, cnb_in;
   logic [LEN_W-1:0] cra_ff, cra_in, crb_ff, crb_in;
   logic [5:0]      ci_ff, ci_in;
   logic [CW-1:0]   ca_ff, ca_in, cb_ff, cb_in;

   always_comb begin
      div_type    sa;
      div_type    sb;
      logic [LEN_W-1:0] r;
      cfg_state_in = cfg_state_ff;
      mu_in    = mu_ff;
      cd_in    = cd_ff;
      ch_in    = ch_ff;
      croot_in = croot_ff;
      ck_in    = ck_ff;
      cna_in   = cna_ff;
      cnb_in   = cnb_ff;
      cra_in   = cra_ff;
      crb_in   = crb_ff;
      ci_in    = ci_ff;
      ca_in    = ca_ff;
      cb_in    = cb_ff;
      r        = croot_ff.r[LEN_W-1:0];
      sa       = div_step(cra_ff, cna_ff[ci_ff], r);
      sb       = div_step(crb_ff, cnb_ff[ci_ff], r);
      case (cfg_state_ff)
         CFG_IDLE: begin
            cfg_state_in = CFG_IDLE;
         end
         CFG_SCALE: begin
            if (cd_ff < D_LIMIT) begin
               cd_in = cd_ff << 2;
               ch_in = ch_ff + 5'd1;
            end else begin
               croot_in = '{v: cd_ff, r: 64'd0};
               ck_in    = '0;
               cfg_state_in = CFG_ROOT;
            end
         end
         CFG_ROOT: begin
            croot_in = root_step(croot_ff, ck_ff);
            ck_in    = ck_ff + 5'd1;
            if (ck_ff == 5'(ROOT_ITERS - 1)) begin
               cfg_state_in = CFG_PREP;
            end
         end
         CFG_PREP: begin
            cna_in = (D_ONE << ch_ff) + 64'(r >> 1);
            cnb_in = ((64'(mu_ff) << ch_ff) << FRAC_BITS) + 64'(r >> 1);
            cra_in = cna_in[QW +: LEN_W];
            crb_in = cnb_in[QW +: LEN_W];
            ci_in  = 6'(QW - 1);
            ca_in  = '0;
            cb_in  = '0;
            cfg_state_in = CFG_DIV;
         end
         CFG_DIV: begin
            cra_in = sa.rem;
            crb_in = sb.rem;
            ca_in  = {ca_ff[CW-2:0], sa.q};
            cb_in  = {cb_ff[CW-2:0], sb.q};
            ci_in  = ci_ff - 6'd1;
            if (ci_ff == 6'd0) begin
               cfg_state_in = CFG_IDLE;
            end
         end
         default: begin
            cfg_state_in = CFG_IDLE;
         end
      endcase
      // A write starts the update from any state, so no write is lost.
      if (csr_wr_en) begin
         mu_in = csr_wr_data;
         cd_in = D_ONE + 64'(40'(csr_wr_data) * 40'(csr_wr_data));
         ch_in = '0;
         cfg_state_in = CFG_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_state_ff <= CFG_IDLE;
         mu_ff        <= '0;
         ca_ff        <= CW'(1) << FRAC_BITS;
         cb_ff        <= '0;
      end else begin
         cfg_state_ff <= cfg_state_in;
         mu_ff        <= mu_in;
         ca_ff        <= ca_in;
         cb_ff        <= cb_in;
      end
      cd_ff    <= cd_in;
      ch_ff    <= ch_in;
      croot_ff <= croot_in;
      ck_ff    <= ck_in;
      cna_ff   <= cna_in;
      cnb_ff   <= cnb_in;
      cra_ff   <= cra_in;
      crb_ff   <= crb_in;
      ci_ff    <= ci_in;
   end

   // ---------------------------------------------------------------- pipeline
   logic en;
   logic o_v_ff;

   assign en         = !o_v_ff || rsp_tready;
   assign req_tready = en && (cfg_state_ff == CFG_IDLE);

   logic signed [FIELD_W-1:0] in_nx, in_ny;
   assign in_nx = req_tdata[2*FIELD_W +: FIELD_W];
   assign in_ny = req_tdata[3*FIELD_W +: FIELD_W];

   // Stage 1: magnitudes and signs.
   logic s1_v_ff;
   side_type s1_sd_ff;
   logic [FIELD_W-1:0] s1_ax_ff, s1_ay_ff;

   // Stage 2: shift that brings the larger magnitude to [2^30, 2^31].
   logic s2_v_ff;
   side_type s2_sd_ff;
   logic [FIELD_W-1:0] s2_ax_ff, s2_ay_ff;
   logic [4:0] s2_sh_ff, s2_sh_in;
   logic [FIELD_W-1:0] s2_m;

   always_comb begin
      s2_m     = (s1_ax_ff > s1_ay_ff) ? s1_ax_ff : s1_ay_ff;
      s2_sh_in = '0;
      for (int i = 0; i < 31; i++) begin
         if (s2_m[i]) begin
            s2_sh_in = 5'(30 - i);
         end
      end
   end

   // Stage 3: shifted components; stage 4: squares.
   logic s3_v_ff;
   side_type s3_sd_ff;
   logic [FIELD_W-1:0] s3_ax_ff, s3_ay_ff;
   logic s4_v_ff;
   side_type s4_sd_ff;
   logic [FIELD_W-1:0] s4_ax_ff, s4_ay_ff;
   logic [63:0] s4_sqx_ff, s4_sqy_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         s1_sd_ff.px <= req_tdata[0 +: FIELD_W];
         s1_sd_ff.py <= req_tdata[FIELD_W +: FIELD_W];
         s1_sd_ff.sx <= in_nx[FIELD_W-1];
         s1_sd_ff.sy <= in_ny[FIELD_W-1];
         s1_sd_ff.zr <= (in_nx == '0) && (in_ny == '0);
         s1_ax_ff    <= in_nx[FIELD_W-1] ? FIELD_W'(-in_nx) : FIELD_W'(in_nx);
         s1_ay_ff    <= in_ny[FIELD_W-1] ? FIELD_W'(-in_ny) : FIELD_W'(in_ny);
         s2_sd_ff    <= s1_sd_ff;
         s2_ax_ff    <= s1_ax_ff;
         s2_ay_ff    <= s1_ay_ff;
         s2_sh_ff    <= s2_sh_in;
         s3_sd_ff    <= s2_sd_ff;
         s3_ax_ff    <= s2_ax_ff << s2_sh_ff;
         s3_ay_ff    <= s2_ay_ff << s2_sh_ff;
         s4_sd_ff    <= s3_sd_ff;
         s4_ax_ff    <= s3_ax_ff;
         s4_ay_ff    <= s3_ay_ff;
         s4_sqx_ff   <= 64'(s3_ax_ff) * 64'(s3_ax_ff);
         s4_sqy_ff   <= 64'(s3_ay_ff) * 64'(s3_ay_ff);
      end
   end

   // Root stages: entry 0 holds the squared length, each later entry two iterations.
   logic               rv_ff  [ROOT_STAGES+1];
   side_type           rsd_ff [ROOT_STAGES+1];
   logic [FIELD_W-1:0] rax_ff [ROOT_STAGES+1];
   logic [FIELD_W-1:0] ray_ff [ROOT_STAGES+1];
   root_type           rt_ff  [ROOT_STAGES+1];
   root_type           rt_in  [ROOT_STAGES+1];

   always_comb begin
      root_type acc;
      rt_in[0] = '{v: s4_sqx_ff + s4_sqy_ff, r: 64'd0};
      for (int g = 1; g <= ROOT_STAGES; g++) begin
         acc = rt_ff[g-1];
         for (int i = 0; i < ROOT_PER_STAGE; i++) begin
            acc = root_step(acc, 5'((g - 1) * ROOT_PER_STAGE + i));
         end
         rt_in[g] = acc;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rt_ff[0]  <= rt_in[0];
         rsd_ff[0] <= s4_sd_ff;
         rax_ff[0] <= s4_ax_ff;
         ray_ff[0] <= s4_ay_ff;
         for (int g = 1; g <= ROOT_STAGES; g++) begin
            rt_ff[g]  <= rt_in[g];
            rsd_ff[g] <= rsd_ff[g-1];
            rax_ff[g] <= rax_ff[g-1];
            ray_ff[g] <= ray_ff[g-1];
         end
      end
   end

   // Divider stages: entry 0 holds the rounded numerators, later entries two steps.
   logic             dv_ff  [DIV_STAGES+1];
   side_type         dsd_ff [DIV_STAGES+1];
   logic [LEN_W-1:0] dl_ff  [DIV_STAGES+1];
   logic [NW-1:0]    dnx_ff [DIV_STAGES+1];
   logic [NW-1:0]    dny_ff [DIV_STAGES+1];
   logic [LEN_W-1:0] drx_ff [DIV_STAGES+1];
   logic [LEN_W-1:0] dry_ff [DIV_STAGES+1];
   logic [QW-1:0]    dqx_ff [DIV_STAGES+1];
   logic [QW-1:0]    dqy_ff [DIV_STAGES+1];
   logic [LEN_W-1:0] drx_in [DIV_STAGES+1];
   logic [LEN_W-1:0] dry_in [DIV_STAGES+1];
   logic [QW-1:0]    dqx_in [DIV_STAGES+1];
   logic [QW-1:0]    dqy_in [DIV_STAGES+1];
   logic [LEN_W-1:0] d0_len;
   logic [NW-1:0]    d0_nx, d0_ny;

   always_comb begin
      div_type       stx;
      div_type       sty;
      logic [QW-1:0] qx;
      logic [QW-1:0] qy;
      int            j;
      d0_len    = rt_ff[ROOT_STAGES].r[LEN_W-1:0];
      d0_nx     = NW'({rax_ff[ROOT_STAGES], {FRAC_BITS{1'b0}}}) + NW'(d0_len >> 1);
      d0_ny     = NW'({ray_ff[ROOT_STAGES], {FRAC_BITS{1'b0}}}) + NW'(d0_len >> 1);
      drx_in[0] = d0_nx[QW +: LEN_W];
      dry_in[0] = d0_ny[QW +: LEN_W];
      dqx_in[0] = '0;
      dqy_in[0] = '0;
      for (int g = 1; g <= DIV_STAGES; g++) begin
         stx = '{rem: drx_ff[g-1], q: 1'b0};
         sty = '{rem: dry_ff[g-1], q: 1'b0};
         qx  = dqx_ff[g-1];
         qy  = dqy_ff[g-1];
         for (int t = 0; t < DIV_PER_STAGE; t++) begin
            j = (g - 1) * DIV_PER_STAGE + t;
            if (j < QW) begin
               stx = div_step(stx.rem, dnx_ff[g-1][QW-1-j], dl_ff[g-1]);
               sty = div_step(sty.rem, dny_ff[g-1][QW-1-j], dl_ff[g-1]);
               qx  = {qx[QW-2:0], stx.q};
               qy  = {qy[QW-2:0], sty.q};
            end
         end
         drx_in[g] = stx.rem;
         dry_in[g] = sty.rem;
         dqx_in[g] = qx;
         dqy_in[g] = qy;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dsd_ff[0] <= rsd_ff[ROOT_STAGES];
         dl_ff[0]  <= d0_len;
         dnx_ff[0] <= d0_nx;
         dny_ff[0] <= d0_ny;
         drx_ff[0] <= drx_in[0];
         dry_ff[0] <= dry_in[0];
         dqx_ff[0] <= dqx_in[0];
         dqy_ff[0] <= dqy_in[0];
         for (int g = 1; g <= DIV_STAGES; g++) begin
            dsd_ff[g] <= dsd_ff[g-1];
            dl_ff[g]  <= dl_ff[g-1];
            dnx_ff[g] <= dnx_ff[g-1];
            dny_ff[g] <= dny_ff[g-1];
            drx_ff[g] <= drx_in[g];
            dry_ff[g] <= dry_in[g];
            dqx_ff[g] <= dqx_in[g];
            dqy_ff[g] <= dqy_in[g];
         end
      end
   end

   // Unit normal with signs restored; a zero normal gives zero directions.
   logic u_v_ff;
   side_type u_sd_ff;
   logic signed [DIRW-1:0] u_ux_ff, u_uy_ff, u_ux_in, u_uy_in;

   always_comb begin
      logic signed [DIRW-1:0] qx;
      logic signed [DIRW-1:0] qy;
      qx = $signed(DIRW'(dqx_ff[DIV_STAGES]));
      qy = $signed(DIRW'(dqy_ff[DIV_STAGES]));
      u_ux_in = dsd_ff[DIV_STAGES].zr ? '0 : (dsd_ff[DIV_STAGES].sx ? -qx : qx);
      u_uy_in = dsd_ff[DIV_STAGES].zr ? '0 : (dsd_ff[DIV_STAGES].sy ? -qy : qy);
   end

   // Cone scale products.
   logic p_v_ff;
   side_type p_sd_ff;
   logic signed [DIRW-1:0] p_ux_ff, p_uy_ff;
   logic signed [PRW-1:0]  p_caux_ff, p_cauy_ff, p_cbux_ff, p_cbuy_ff;

   // Edge directions: left = ca*n + cb*t, right = ca*n - cb*t, with t = (-uy, ux).
   logic e_v_ff;
   side_type e_sd_ff;
   logic signed [DIRW-1:0] e_ux_ff, e_uy_ff;
   logic signed [DIRW-1:0] e_lx_ff, e_ly_ff, e_rx_ff, e_ry_ff;
   logic signed [DIRW-1:0] e_lx_in, e_ly_in, e_rx_in, e_ry_in;

   always_comb begin
      e_lx_in = DIRW'(rnd_frac(TRW'(p_caux_ff) - TRW'(p_cbuy_ff)));
      e_ly_in = DIRW'(rnd_frac(TRW'(p_cauy_ff) + TRW'(p_cbux_ff)));
      e_rx_in = DIRW'(rnd_frac(TRW'(p_caux_ff) + TRW'(p_cbuy_ff)));
      e_ry_in = DIRW'(rnd_frac(TRW'(p_cauy_ff) - TRW'(p_cbux_ff)));
   end

   // Moment products.
   logic t_v_ff;
   logic signed [DIRW-1:0] t_ux_ff, t_uy_ff, t_lx_ff, t_ly_ff, t_rx_ff, t_ry_ff;
   logic signed [TPW-1:0]  t_pxuy_ff, t_pyux_ff, t_pxux_ff, t_pyuy_ff;
   logic signed [TPW-1:0]  t_pxly_ff, t_pylx_ff, t_pxry_ff, t_pyrx_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         u_sd_ff   <= dsd_ff[DIV_STAGES];
         u_ux_ff   <= u_ux_in;
         u_uy_ff   <= u_uy_in;
         p_sd_ff   <= u_sd_ff;
         p_ux_ff   <= u_ux_ff;
         p_uy_ff   <= u_uy_ff;
         p_caux_ff <= $signed({1'b0, ca_ff}) * u_ux_ff;
         p_cauy_ff <= $signed({1'b0, ca_ff}) * u_uy_ff;
         p_cbux_ff <= $signed({1'b0, cb_ff}) * u_ux_ff;
         p_cbuy_ff <= $signed({1'b0, cb_ff}) * u_uy_ff;
         e_sd_ff   <= p_sd_ff;
         e_ux_ff   <= p_ux_ff;
         e_uy_ff   <= p_uy_ff;
         e_lx_ff   <= e_lx_in;
         e_ly_ff   <= e_ly_in;
         e_rx_ff   <= e_rx_in;
         e_ry_ff   <= e_ry_in;
         t_ux_ff   <= e_ux_ff;
         t_uy_ff   <= e_uy_ff;
         t_lx_ff   <= e_lx_ff;
         t_ly_ff   <= e_ly_ff;
         t_rx_ff   <= e_rx_ff;
         t_ry_ff   <= e_ry_ff;
         t_pxuy_ff <= e_sd_ff.px * e_uy_ff;
         t_pyux_ff <= e_sd_ff.py * e_ux_ff;
         t_pxux_ff <= e_sd_ff.px * e_ux_ff;
         t_pyuy_ff <= e_sd_ff.py * e_uy_ff;
         t_pxly_ff <= e_sd_ff.px * e_ly_ff;
         t_pylx_ff <= e_sd_ff.py * e_lx_ff;
         t_pxry_ff <= e_sd_ff.px * e_ry_ff;
         t_pyrx_ff <= e_sd_ff.py * e_rx_ff;
      end
   end

   // Output register: moments rounded, every field saturated.
   logic [12*FIELD_W-1:0] o_data_ff, o_data_in;

   always_comb begin
      o_data_in = {
         sat_out(rnd_frac(TRW'(t_pxry_ff) - TRW'(t_pyrx_ff))),
         sat_out(TRW'(t_ry_ff)),
         sat_out(TRW'(t_rx_ff)),
         sat_out(rnd_frac(TRW'(t_pxly_ff) - TRW'(t_pylx_ff))),
         sat_out(TRW'(t_ly_ff)),
         sat_out(TRW'(t_lx_ff)),
         sat_out(rnd_frac(TRW'(t_pxux_ff) + TRW'(t_pyuy_ff))),
         sat_out(TRW'(t_ux_ff)),
         sat_out(-TRW'(t_uy_ff)),
         sat_out(rnd_frac(TRW'(t_pxuy_ff) - TRW'(t_pyux_ff))),
         sat_out(TRW'(t_uy_ff)),
         sat_out(TRW'(t_ux_ff))
      };
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_data_ff <= o_data_in;
      end
   end

   // Valid bits travel with the data and advance together with it.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
         s4_v_ff <= 1'b0;
         for (int g = 0; g <= ROOT_STAGES; g++) begin
            rv_ff[g] <= 1'b0;
         end
         for (int g = 0; g <= DIV_STAGES; g++) begin
            dv_ff[g] <= 1'b0;
         end
         u_v_ff <= 1'b0;
         p_v_ff <= 1'b0;
         e_v_ff <= 1'b0;
         t_v_ff <= 1'b0;
         o_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff  <= req_tvalid && req_tready;
         s2_v_ff  <= s1_v_ff;
         s3_v_ff  <= s2_v_ff;
         s4_v_ff  <= s3_v_ff;
         rv_ff[0] <= s4_v_ff;
         for (int g = 1; g <= ROOT_STAGES; g++) begin
            rv_ff[g] <= rv_ff[g-1];
         end
         dv_ff[0] <= rv_ff[ROOT_STAGES];
         for (int g = 1; g <= DIV_STAGES; g++) begin
            dv_ff[g] <= dv_ff[g-1];
         end
         u_v_ff <= dv_ff[DIV_STAGES];
         p_v_ff <= u_v_ff;
         e_v_ff <= p_v_ff;
         t_v_ff <= e_v_ff;
         o_v_ff <= t_v_ff;
      end
   end

   assign rsp_tvalid = o_v_ff;
   assign rsp_tdata  = o_data_ff;

   // ---------------------------------------------------------------- checks
   localparam logic signed [FIELD_W-1:0] UNIT = FIELD_W'(1) << FRAC_BITS;

   a_busy_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (cfg_state_ff != CFG_IDLE) |-> !req_tready)
      else $error("request accepted while cone scales are being recomputed");

   a_write_starts_update: assert property (@(posedge clock) disable iff (reset)
      (csr_wr_en && (cfg_state_ff == CFG_IDLE)) |=> (cfg_state_ff == CFG_SCALE))
      else $error("friction write did not start a scale update");

   a_scales_bounded: assert property (@(posedge clock) disable iff (reset)
      (cfg_state_ff == CFG_IDLE) |-> ((ca_ff <= CW'(UNIT)) && (cb_ff <= CW'(UNIT))))
      else $error("cone scale exceeds one");

   a_unit_normal_bounded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (($signed(rsp_tdata[FIELD_W-1:0]) <= UNIT)
                   && ($signed(rsp_tdata[FIELD_W-1:0]) >= -UNIT)
                   && ($signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) <= UNIT)
                   && ($signed(rsp_tdata[2*FIELD_W-1:FIELD_W]) >= -UNIT)))
      else $error("unit normal component out of range");

endmodule

`default_nettype wire
